### sv/fast_corner_test_defines.svh
// Assertion macros shared by the fast corner test RTL.
`ifndef FAST_CORNER_TEST_DEFINES_SVH
`define FAST_CORNER_TEST_DEFINES_SVH
`ifndef SYNTH
`define FCT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FCT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FCT_ASSERT(label, clk, rst_n, prop, msg)
`define FCT_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

### sv/fct_pkg.sv
// Types, constants and helper functions of the fast corner test.
`timescale 1ns / 1ps
package fct_pkg;

    localparam int RING_SIZE = 16;
    localparam int PIX_W     = 8;
    localparam int RING_W    = RING_SIZE * PIX_W;
    localparam int HALF_W    = RING_W / 2;

    localparam logic [7:0] THRESHOLD_RESET  = 8'd20;
    localparam logic [4:0] RUN_LENGTH_RESET = 5'd9;

    // Register index as decoded from paddr[2].
    localparam logic REG_THRESHOLD  = 1'b0;
    localparam logic REG_RUN_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_DARK   = 2'd1,
        KIND_BRIGHT = 2'd2
    } kind_t;

    // One classified request handed from the front end to the back end.
    typedef struct packed {
        logic [PIX_W-1:0]     center;
        logic [RING_W-1:0]    ring;
        kind_t                kind;
        logic [RING_SIZE-1:0] pass;
    } fct_item_t;

    function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        logic [PIX_W-1:0] d;
        begin
            if (a >= b)
            begin
                d = a - b;
            end
            else
            begin
                d = b - a;
            end
            return d;
        end
    endfunction

endpackage

### sv/fct_if.sv
// Valid/ready channel interfaces for the input and result requests.
`timescale 1ns / 1ps
interface fct_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  center_pixel;
    logic [63:0] ring_low;
    logic [63:0] ring_high;

    modport source (output valid, output center_pixel, output ring_low,
                    output ring_high, input ready);
    modport sink (input valid, input center_pixel, input ring_low,
                  input ring_high, output ready);
endinterface

interface fct_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] corner_score;
    logic [1:0] corner_kind;

    modport source (output valid, output corner_score, output corner_kind,
                    input ready);
    modport sink (input valid, input corner_score, input corner_kind,
                  output ready);
endinterface

### sv/fct_front.sv
// Front end: registers each request and runs the compass pretest.
`timescale 1ns / 1ps
module fct_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        threshold,
    fct_in_if.sink            in_ch,
    output logic              item_valid,
    output fct_pkg::fct_item_t item,
    input  logic              item_ready
);

    logic [fct_pkg::PIX_W-1:0]     px [fct_pkg::RING_SIZE];
    logic [fct_pkg::RING_SIZE-1:0] dark;
    logic [fct_pkg::RING_SIZE-1:0] bright;
    logic [fct_pkg::RING_W-1:0]    ring;
    fct_pkg::kind_t                kind;
    logic [fct_pkg::RING_SIZE-1:0] pass;
    logic                          take;

    logic               valid_reg;
    logic               valid_next;
    fct_pkg::fct_item_t item_reg;

    assign ring = {in_ch.ring_high, in_ch.ring_low};

    // Darker means c - T >= p, brighter means c + T <= p, both without wrap.
    always_comb
    begin
        for (int i = 0; i < fct_pkg::RING_SIZE; i++)
        begin
            px[i]     = ring[i*fct_pkg::PIX_W +: fct_pkg::PIX_W];
            dark[i]   = ({1'b0, px[i]} + {1'b0, threshold}) <= {1'b0, in_ch.center_pixel};
            bright[i] = ({1'b0, in_ch.center_pixel} + {1'b0, threshold}) <= {1'b0, px[i]};
        end
    end

    always_comb
    begin
        priority if (dark[0] && dark[4] && dark[8])
            kind = fct_pkg::KIND_DARK;
        else if (bright[0] && bright[4] && bright[8])
            kind = fct_pkg::KIND_BRIGHT;
        else if (dark[4] && dark[8] && dark[12])
            kind = fct_pkg::KIND_DARK;
        else if (bright[4] && bright[8] && bright[12])
            kind = fct_pkg::KIND_BRIGHT;
        else if (dark[8] && dark[12] && dark[0])
            kind = fct_pkg::KIND_DARK;
        else if (bright[8] && bright[12] && bright[0])
            kind = fct_pkg::KIND_BRIGHT;
        else if (dark[12] && dark[0] && dark[4])
            kind = fct_pkg::KIND_DARK;
        else if (bright[12] && bright[0] && bright[4])
            kind = fct_pkg::KIND_BRIGHT;
        else
            kind = fct_pkg::KIND_NONE;
    end

    always_comb
    begin
        unique case (kind)
            fct_pkg::KIND_DARK:   pass = dark;
            fct_pkg::KIND_BRIGHT: pass = bright;
            default:              pass = '0;
        endcase
    end

    assign in_ch.ready = !valid_reg || item_ready;
    assign take        = in_ch.valid && in_ch.ready;
    assign valid_next  = take || (valid_reg && !item_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.center <= in_ch.center_pixel;
            item_reg.ring   <= ring;
            item_reg.kind   <= kind;
            item_reg.pass   <= pass;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### sv/fct_queue.sv
// Small FIFO that decouples the front end from the back end.
`timescale 1ns / 1ps
`include "fast_corner_test_defines.svh"
module fct_queue #(
    parameter int DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    input  fct_pkg::fct_item_t push_item,
    output logic               push_ready,
    output logic               pop_valid,
    output fct_pkg::fct_item_t pop_item,
    input  logic               pop_ready
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    fct_pkg::fct_item_t mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               push;
    logic               pop;

    assign push_ready = count_reg != FULL;
    assign pop_valid  = count_reg != '0;
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    `FCT_ASSERT(a_count_bound, clk, rst_n, count_reg <= FULL, "queue count above depth")
    `FCT_ASSERT(a_ptr_gap, clk, rst_n, (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg), "empty queue with pointers apart")

endmodule

### sv/fct_back.sv
// Back end: contiguous run search and the two-stage score fold.
`timescale 1ns / 1ps
`include "fast_corner_test_defines.svh"
module fct_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [4:0]         run_length,
    input  logic               item_valid,
    input  fct_pkg::fct_item_t item,
    output logic               item_ready,
    fct_out_if.source          out_ch
);

    localparam int N = fct_pkg::RING_SIZE;
    localparam int W = fct_pkg::PIX_W;

    logic [N-1:0]        len_mask;
    logic [2*N-1:0]      pass_dbl;
    logic                run_hit;
    logic [W-1:0]        fold_a;
    logic [W-1:0]        fold_b;
    fct_pkg::kind_t      kind_s1;
    fct_pkg::kind_t      kind_s2;
    logic                take1;
    logic                take2;
    logic                ready2;

    logic                      v1_reg;
    logic                      v1_next;
    logic [W-1:0]              score1_reg;
    logic [fct_pkg::HALF_W-1:0] ring_hi_reg;
    fct_pkg::kind_t            kind1_reg;

    logic                v2_reg;
    logic                v2_next;
    logic [W-1:0]        score2_reg;
    fct_pkg::kind_t      kind2_reg;

    // A run length of zero gives an empty mask; above the ring size it clamps.
    always_comb
    begin
        for (int j = 0; j < N; j++)
        begin
            len_mask[j] = 5'(j) < run_length;
        end
    end

    assign pass_dbl = {item.pass, item.pass};

    always_comb
    begin
        run_hit = 1'b0;
        for (int s = 0; s < N; s++)
        begin
            if ((pass_dbl[s +: N] & len_mask) == len_mask)
            begin
                run_hit = 1'b1;
            end
        end
    end

    assign kind_s1 = (run_hit && item.kind != fct_pkg::KIND_NONE) ? item.kind
                                                                  : fct_pkg::KIND_NONE;

    // First half of the fold over ring pixels 0 to 7.
    always_comb
    begin
        fold_a = item.center;
        for (int i = 0; i < N / 2; i++)
        begin
            fold_a = fct_pkg::abs_diff(fold_a, item.ring[i*W +: W]);
        end
    end

    // Second half of the fold over ring pixels 8 to 15.
    always_comb
    begin
        fold_b = score1_reg;
        for (int i = 0; i < N / 2; i++)
        begin
            fold_b = fct_pkg::abs_diff(fold_b, ring_hi_reg[i*W +: W]);
        end
    end

    always_comb
    begin
        kind_s2 = kind1_reg;
        if (kind1_reg == fct_pkg::KIND_NONE || fold_b == '0)
        begin
            kind_s2 = fct_pkg::KIND_NONE;
        end
    end

    assign ready2     = !v2_reg || out_ch.ready;
    assign item_ready = !v1_reg || ready2;
    assign take1      = item_valid && item_ready;
    assign take2      = v1_reg && ready2;
    assign v1_next    = take1 || (v1_reg && !ready2);
    assign v2_next    = take2 || (v2_reg && !out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take1)
        begin
            score1_reg  <= fold_a;
            ring_hi_reg <= item.ring[fct_pkg::RING_W-1:fct_pkg::HALF_W];
            kind1_reg   <= kind_s1;
        end
        if (take2)
        begin
            score2_reg <= (kind_s2 == fct_pkg::KIND_NONE) ? '0 : fold_b;
            kind2_reg  <= kind_s2;
        end
    end

    assign out_ch.valid        = v2_reg;
    assign out_ch.corner_score = score2_reg;
    assign out_ch.corner_kind  = kind2_reg;

    `FCT_ASSERT(a_kind_score, clk, rst_n, v2_reg |-> ((kind2_reg == fct_pkg::KIND_NONE) == (score2_reg == '0)), "corner kind and score disagree")
    `FCT_ASSERT(a_no_pass_no_kind, clk, rst_n, (take1 && item.pass == '0 && run_length != '0) |=> (kind1_reg == fct_pkg::KIND_NONE), "kind kept without passing pixels")

endmodule

### sv/fast_corner_test.sv
// Top level of the fast corner test: configuration registers and the pipeline.
`timescale 1ns / 1ps
// The block takes one request per clock unless stalled and returns one result per
// request in order. A request passes a registered pretest stage, a small queue and
// two back-end stages; the score fold over the sixteen ring pixels is split across
// the two back-end stages. Either side may stall without loss. The user must write
// threshold and run_length over the APB port at byte addresses 0 and 4 only while
// no request is in flight; the block itself does not enforce it.
module fast_corner_test #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    fct_in_if.sink      in_ch,
    fct_out_if.source   out_ch
);

    logic [7:0]         threshold_reg;
    logic [4:0]         run_length_reg;
    logic               wr_en;
    logic               front_valid;
    fct_pkg::fct_item_t front_item;
    logic               front_ready;
    logic               back_valid;
    fct_pkg::fct_item_t back_item;
    logic               back_ready;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= fct_pkg::THRESHOLD_RESET;
            run_length_reg <= fct_pkg::RUN_LENGTH_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                fct_pkg::REG_THRESHOLD:  threshold_reg  <= pwdata[7:0];
                fct_pkg::REG_RUN_LENGTH: run_length_reg <= pwdata[4:0];
                default:                 threshold_reg  <= threshold_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            fct_pkg::REG_THRESHOLD:  prdata = {24'd0, threshold_reg};
            fct_pkg::REG_RUN_LENGTH: prdata = {27'd0, run_length_reg};
            default:                 prdata = '0;
        endcase
    end

    fct_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .threshold  (threshold_reg),
        .in_ch      (in_ch),
        .item_valid (front_valid),
        .item       (front_item),
        .item_ready (front_ready)
    );

    fct_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_item  (front_item),
        .push_ready (front_ready),
        .pop_valid  (back_valid),
        .pop_item   (back_item),
        .pop_ready  (back_ready)
    );

    fct_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .run_length (run_length_reg),
        .item_valid (back_valid),
        .item       (back_item),
        .item_ready (back_ready),
        .out_ch     (out_ch)
    );

endmodule

### tb/tb_top.sv
// Self-checking testbench of the fast corner test block with random flow control.
`timescale 1ns / 1ps
module tb_top;

    typedef struct {
        logic [7:0]   center;
        logic [127:0] ring;
    } pixel_req_t;

    typedef struct {
        logic [7:0]      score;
        fct_pkg::kind_t  kind;
    } corner_res_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    fct_in_if  in_bus ();
    fct_out_if out_bus ();

    fast_corner_test dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_bus),
        .out_ch  (out_bus)
    );

    pixel_req_t  pixel_queue[$];
    corner_res_t expected_scores[$];

    logic [7:0] cur_threshold;
    logic [4:0] cur_run_length;
    bit         quiet_run;
    int         err_count;
    int         sent_count;
    int         dark_count;
    int         bright_count;
    int         setting_count;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic bit pix_ok(input fct_pkg::kind_t k, input int c, input int t,
                                  input int p);
        if (k == fct_pkg::KIND_DARK)
        begin
            return c - t >= p;
        end
        return c + t <= p;
    endfunction

    // Segment test: compass pretest, cyclic run search, then the score fold.
    function automatic corner_res_t predict_corner(input logic [7:0] c,
                                                   input logic [127:0] ring,
                                                   input logic [7:0] thr,
                                                   input logic [4:0] runlen);
        corner_res_t    r;
        fct_pkg::kind_t cls;
        int             px[16];
        int             ci;
        int             t;
        int             n;
        int             s;
        int             a;
        int             b;
        int             d;
        bit             found;
        bit             ok;
        ci = c;
        t = thr;
        n = (runlen > 16) ? 16 : runlen;
        for (int k = 0; k < 16; k++)
        begin
            px[k] = ring[8*k +: 8];
        end
        cls = fct_pkg::KIND_NONE;
        for (int k = 0; k < 4; k++)
        begin
            a = px[4*k];
            b = px[4*((k + 1) & 3)];
            d = px[4*((k + 2) & 3)];
            if (cls == fct_pkg::KIND_NONE && pix_ok(fct_pkg::KIND_DARK, ci, t, a)
                && pix_ok(fct_pkg::KIND_DARK, ci, t, b)
                && pix_ok(fct_pkg::KIND_DARK, ci, t, d))
            begin
                cls = fct_pkg::KIND_DARK;
            end
            if (cls == fct_pkg::KIND_NONE && pix_ok(fct_pkg::KIND_BRIGHT, ci, t, a)
                && pix_ok(fct_pkg::KIND_BRIGHT, ci, t, b)
                && pix_ok(fct_pkg::KIND_BRIGHT, ci, t, d))
            begin
                cls = fct_pkg::KIND_BRIGHT;
            end
        end
        found = 1'b0;
        if (cls != fct_pkg::KIND_NONE)
        begin
            for (int st = 0; st < 16; st++)
            begin
                ok = 1'b1;
                for (int j = 0; j < n; j++)
                begin
                    if (!pix_ok(cls, ci, t, px[(st + j) % 16]))
                    begin
                        ok = 1'b0;
                    end
                end
                if (ok)
                begin
                    found = 1'b1;
                end
            end
        end
        s = 0;
        if (found)
        begin
            s = ci;
            for (int k = 0; k < 16; k++)
            begin
                s = (s >= px[k]) ? s - px[k] : px[k] - s;
            end
        end
        r.score = s[7:0];
        r.kind = (s == 0) ? fct_pkg::KIND_NONE : cls;
        return r;
    endfunction

    task automatic note_error(input string msg);
        err_count++;
        if (err_count <= 10)
        begin
            $display("%0t ns: %s", $realtime, msg);
        end
    endtask

    // Request driver: a new request goes out once the current one is taken.
    always @(posedge clk)
    begin : req_driver
        pixel_req_t r;
        if (!rst_n)
        begin
            in_bus.valid <= 1'b0;
        end
        else if (!in_bus.valid || in_bus.ready)
        begin
            if (in_bus.valid)
            begin
                expected_scores.push_back(predict_corner(in_bus.center_pixel,
                    {in_bus.ring_high, in_bus.ring_low}, cur_threshold, cur_run_length));
                sent_count++;
            end
            if (pixel_queue.size() != 0 && (quiet_run || $urandom_range(0, 99) >= 6))
            begin
                r = pixel_queue.pop_front();
                in_bus.valid <= 1'b1;
                in_bus.center_pixel <= r.center;
                in_bus.ring_low <= r.ring[63:0];
                in_bus.ring_high <= r.ring[127:64];
            end
            else
            begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_bus.ready <= 1'b0;
        end
        else
        begin
            out_bus.ready <= quiet_run || ($urandom_range(0, 99) >= 6);
        end
    end

    always @(posedge clk)
    begin : result_monitor
        corner_res_t e;
        if (rst_n && out_bus.valid && out_bus.ready)
        begin
            if (expected_scores.size() == 0)
            begin
                note_error($sformatf("unexpected result score %0d kind %0d",
                                     out_bus.corner_score, out_bus.corner_kind));
            end
            else
            begin
                e = expected_scores.pop_front();
                if (out_bus.corner_score !== e.score || out_bus.corner_kind !== e.kind)
                begin
                    note_error($sformatf("expected score %0d kind %0d, got score %0d kind %0d",
                                         e.score, e.kind, out_bus.corner_score,
                                         out_bus.corner_kind));
                end
                if (e.kind == fct_pkg::KIND_DARK)
                begin
                    dark_count++;
                end
                if (e.kind == fct_pkg::KIND_BRIGHT)
                begin
                    bright_count++;
                end
            end
        end
    end

    task automatic push_ring(input logic [7:0] c, input logic [127:0] ring);
        pixel_req_t r;
        r.center = c;
        r.ring = ring;
        pixel_queue.push_back(r);
    endtask

    // Ring of one base value with a run of another value, wrapping past pixel 15.
    task automatic queue_run(input logic [7:0] c, input logic [7:0] base, input logic [7:0] runval,
                             input int start, input int len);
        logic [127:0] ring;
        ring = {16{base}};
        for (int j = 0; j < len; j++)
        begin
            ring[8*((start + j) % 16) +: 8] = runval;
        end
        push_ring(c, ring);
    endtask

    function automatic logic [7:0] dark_pixel(input int c, input int t);
        if (c >= t)
        begin
            return 8'($urandom_range(0, c - t));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] bright_pixel(input int c, input int t);
        if (c + t <= 255)
        begin
            return 8'($urandom_range(c + t, 255));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly rings with a passing arc of random length, the rest plain noise.
    task automatic queue_random_item();
        logic [127:0] ring;
        logic [7:0]   c;
        int           n;
        int           len;
        int           start;
        bit           dark;
        int           near;
        if ($urandom_range(0, 3) == 0)
        begin
            push_ring(8'($urandom), {$urandom, $urandom, $urandom, $urandom});
        end
        else
        begin
            c = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 8'd255 : 8'd0)
                                           : 8'($urandom_range(0, 255));
            dark = 1'($urandom_range(0, 1));
            n = (cur_run_length > 16) ? 16 : cur_run_length;
            len = ($urandom_range(0, 9) < 7) ? $urandom_range((n > 0) ? n - 1 : 0, 16)
                                            : $urandom_range(0, 16);
            start = $urandom_range(0, 15);
            for (int k = 0; k < 16; k++)
            begin
                near = int'(c) + $urandom_range(0, 2 * cur_threshold + 2) - cur_threshold - 1;
                if (near < 0)
                begin
                    near = 0;
                end
                if (near > 255)
                begin
                    near = 255;
                end
                ring[8*k +: 8] = $urandom_range(0, 1) ? 8'(near) : 8'($urandom_range(0, 255));
            end
            for (int j = 0; j < len; j++)
            begin
                ring[8*((start + j) % 16) +: 8] = dark ? dark_pixel(c, cur_threshold)
                                                       : bright_pixel(c, cur_threshold);
            end
            push_ring(c, ring);
        end
    endtask

    task automatic wait_idle();
        do
        begin
            @(negedge clk);
        end
        while (pixel_queue.size() != 0 || in_bus.valid || expected_scores.size() != 0);
    endtask

    task automatic apb_write(input logic reg_sel, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_sel == fct_pkg::REG_THRESHOLD)
        begin
            cur_threshold = value[7:0];
        end
        else
        begin
            cur_run_length = value[4:0];
        end
    endtask

    task automatic set_config(input logic [7:0] thr, input logic [4:0] runlen);
        wait_idle();
        apb_write(fct_pkg::REG_THRESHOLD, {24'd0, thr});
        apb_write(fct_pkg::REG_RUN_LENGTH, {27'd0, runlen});
        setting_count++;
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_bus.valid = 1'b0;
        in_bus.center_pixel = '0;
        in_bus.ring_low = '0;
        in_bus.ring_high = '0;
        out_bus.ready = 1'b0;
        cur_threshold = fct_pkg::THRESHOLD_RESET;
        cur_run_length = fct_pkg::RUN_LENGTH_RESET;
        quiet_run = 1'b0;
        err_count = 0;
        sent_count = 0;
        dark_count = 0;
        bright_count = 0;
        setting_count = 1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset settings: each pretest triple, both classes,
        // the threshold boundary, a run one short, and a fold that lands on zero.
        queue_run(8'd100, 8'd100, 8'd0, 0, 9);
        queue_run(8'd100, 8'd100, 8'd200, 0, 9);
        queue_run(8'd100, 8'd100, 8'd0, 4, 9);
        queue_run(8'd100, 8'd100, 8'd220, 8, 9);
        queue_run(8'd100, 8'd100, 8'd0, 12, 9);
        queue_run(8'd100, 8'd100, 8'd100, 0, 0);
        queue_run(8'd100, 8'd100, 8'd0, 0, 8);
        queue_run(8'd0, 8'd255, 8'd255, 0, 0);
        queue_run(8'd255, 8'd0, 8'd0, 0, 0);
        queue_run(8'd0, 8'd0, 8'd0, 0, 0);
        queue_run(8'd255, 8'd255, 8'd255, 0, 0);
        queue_run(8'd100, 8'd0, 8'd50, 0, 2);
        queue_run(8'd100, 8'd80, 8'd80, 0, 0);
        queue_run(8'd100, 8'd81, 8'd81, 0, 0);
        queue_run(8'd100, 8'd120, 8'd120, 0, 0);
        queue_run(8'd100, 8'd119, 8'd119, 0, 0);
        push_ring(8'hA5, {16{8'h5A}});

        // Zero threshold with an empty run, then the widest threshold with a run
        // length above the ring size.
        set_config(8'd0, 5'd0);
        queue_run(8'd7, 8'd7, 8'd7, 0, 0);
        queue_run(8'd200, 8'd200, 8'd13, 3, 1);
        queue_run(8'd9, 8'd0, 8'd9, 5, 2);
        set_config(8'd255, 5'd31);
        queue_run(8'd255, 8'd0, 8'd0, 0, 0);
        queue_run(8'd0, 8'd255, 8'd255, 0, 0);
        queue_run(8'd254, 8'd0, 8'd0, 0, 0);
        queue_run(8'd255, 8'd0, 8'd1, 6, 1);

        for (int ph = 0; ph < 10; ph++)
        begin
            unique case (ph)
                0: set_config(8'd0, 5'd16);
                1: set_config(8'd255, 5'd0);
                2: set_config(8'd1, 5'd31);
                3: set_config(8'd35, 5'd12);
                4: set_config(8'd8, 5'd17);
                default:
                begin
                    set_config(($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 8'd255 : 8'd0)
                                                          : 8'($urandom_range(0, 60)),
                               $urandom_range(0, 1) ? 5'($urandom_range(8, 13))
                                                    : 5'($urandom_range(0, 31)));
                end
            endcase
            quiet_run = (ph == 3);
            for (int i = 0; i < 125; i++)
            begin
                queue_random_item();
            end
        end

        wait_idle();
        quiet_run = 1'b0;
        repeat (20) @(posedge clk);
        $display("Covered %0d requests over %0d register settings.", sent_count, setting_count);
        $display("Results seen: %0d dark corners, %0d bright corners, %0d errors.",
                 dark_count, bright_count, err_count);
        if (err_count == 0 && expected_scores.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

### sim.f
+incdir+sv
sv/fct_pkg.sv
sv/fct_if.sv
sv/fct_front.sv
sv/fct_queue.sv
sv/fct_back.sv
sv/fast_corner_test.sv
tb/tb_top.sv
